>>> rtl/gda_pkg.sv
package gda_pkg;

   // field widths
   localparam int COUNT_WIDTH = 16;
   localparam int YEAR_WIDTH  = 14;
   localparam int MONTH_WIDTH = 4;
   localparam int DAY_WIDTH   = 5;

   // year modulo 25 residue, used for the century rule
   localparam int CENTURY_FACTOR = 25;
   localparam int M25_WIDTH      = 5;

   // reciprocal of 25: quotient = (year * M25_RECIP) >> M25_SHIFT, exact for
   // every year of YEAR_WIDTH bits
   localparam int M25_SHIFT       = YEAR_WIDTH + 5;
   localparam int M25_RECIP_WIDTH = YEAR_WIDTH + 1;
   localparam int M25_QUOT_WIDTH  = YEAR_WIDTH - 4;
   localparam logic [M25_RECIP_WIDTH-1:0] M25_RECIP =
      M25_RECIP_WIDTH'(((1 << M25_SHIFT) + CENTURY_FACTOR - 1) / CENTURY_FACTOR);

   // calendar constants
   localparam logic [MONTH_WIDTH-1:0] MONTH_JAN = MONTH_WIDTH'(1);
   localparam logic [MONTH_WIDTH-1:0] MONTH_FEB = MONTH_WIDTH'(2);
   localparam logic [MONTH_WIDTH-1:0] MONTH_APR = MONTH_WIDTH'(4);
   localparam logic [MONTH_WIDTH-1:0] MONTH_JUN = MONTH_WIDTH'(6);
   localparam logic [MONTH_WIDTH-1:0] MONTH_SEP = MONTH_WIDTH'(9);
   localparam logic [MONTH_WIDTH-1:0] MONTH_NOV = MONTH_WIDTH'(11);
   localparam logic [MONTH_WIDTH-1:0] MONTH_DEC = MONTH_WIDTH'(12);

   localparam logic [DAY_WIDTH-1:0] DAY_FIRST = DAY_WIDTH'(1);
   localparam logic [DAY_WIDTH-1:0] LEN_FEB_LEAP = DAY_WIDTH'(29);
   localparam logic [DAY_WIDTH-1:0] LEN_FEB      = DAY_WIDTH'(28);
   localparam logic [DAY_WIDTH-1:0] LEN_SHORT    = DAY_WIDTH'(30);
   localparam logic [DAY_WIDTH-1:0] LEN_LONG     = DAY_WIDTH'(31);

   localparam int YEAR_LEN_WIDTH = 9;
   localparam logic [YEAR_LEN_WIDTH-1:0] YEAR_DAYS = YEAR_LEN_WIDTH'(365);

   // shared subtractor width: wide enough for count and year length, plus borrow
   localparam int SUB_WIDTH = ((COUNT_WIDTH > YEAR_LEN_WIDTH) ? COUNT_WIDTH
                                                              : YEAR_LEN_WIDTH) + 1;

   // reset date
   localparam int RESET_YEAR_INT = 1900;
   localparam logic [YEAR_WIDTH-1:0] RESET_YEAR = YEAR_WIDTH'(RESET_YEAR_INT);
   localparam logic [M25_WIDTH-1:0]  RESET_M25  =
      M25_WIDTH'((RESET_YEAR_INT % (1 << YEAR_WIDTH)) % CENTURY_FACTOR);

   // stream packing
   localparam int REQ_DATA_WIDTH =
      ((COUNT_WIDTH + MONTH_WIDTH + DAY_WIDTH + YEAR_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH =
      ((MONTH_WIDTH + DAY_WIDTH + YEAR_WIDTH + 7) / 8) * 8;
   localparam int REQ_MONTH_LSB = COUNT_WIDTH;
   localparam int REQ_DAY_LSB   = REQ_MONTH_LSB + MONTH_WIDTH;
   localparam int REQ_YEAR_LSB  = REQ_DAY_LSB + DAY_WIDTH;

   localparam logic REQ_KIND_ADVANCE = 1'b0;
   localparam logic REQ_KIND_LOAD    = 1'b1;

   // result of the shared subtract and compare unit
   typedef struct packed {
      logic                   take;
      logic [COUNT_WIDTH-1:0] diff;
   } alu_res_type;

   // leap rule from the low year bits and the residue modulo 25:
   // a multiple of 4 is a century when it is also a multiple of 25, and a
   // century is leap only when also a multiple of 16
   function automatic logic is_leap(input logic [3:0] y_low,
                                    input logic [M25_WIDTH-1:0] m25);
      return (y_low[1:0] == 2'd0) && ((m25 != '0) || (y_low == 4'd0));
   endfunction

   function automatic logic [DAY_WIDTH-1:0] month_length(
         input logic [MONTH_WIDTH-1:0] month, input logic leap);
      logic [DAY_WIDTH-1:0] len;
      len = LEN_LONG;
      if (month == MONTH_FEB) begin
         len = leap ? LEN_FEB_LEAP : LEN_FEB;
      end else if ((month == MONTH_APR) || (month == MONTH_JUN) ||
                   (month == MONTH_SEP) || (month == MONTH_NOV)) begin
         len = LEN_SHORT;
      end
      return len;
   endfunction

endpackage

>>> rtl/gda_mod25.sv
// Residue of a year modulo 25 by reciprocal multiplication: the quotient is
// registered after the multiply, the residue in the cycle after that.
module gda_mod25 import gda_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [YEAR_WIDTH-1:0] value,
   output logic                  done,
   output logic [M25_WIDTH-1:0]  residue
);

   localparam int PROD_WIDTH = 2 * YEAR_WIDTH + 1;

   logic [YEAR_WIDTH-1:0]     value_ff, value_in;
   logic [M25_QUOT_WIDTH-1:0] quot_ff, quot_in;
   logic [M25_WIDTH-1:0]      rem_ff, rem_in;
   logic                      mul_ff, mul_in;
   logic                      sub_ff, sub_in;
   logic                      done_ff, done_in;
   logic [PROD_WIDTH-1:0]     product;
   logic [YEAR_WIDTH-1:0]     back;

   // quotient from the reciprocal, then the residue as value - 25 * quotient
   always_comb begin
      product  = PROD_WIDTH'(value_ff) * PROD_WIDTH'(M25_RECIP);
      back     = YEAR_WIDTH'(quot_ff) * YEAR_WIDTH'(CENTURY_FACTOR);
      value_in = start ? value : value_ff;
      quot_in  = mul_ff ? product[M25_SHIFT +: M25_QUOT_WIDTH] : quot_ff;
      rem_in   = sub_ff ? M25_WIDTH'(value_ff - back) : rem_ff;
      mul_in   = start;
      sub_in   = mul_ff;
      done_in  = sub_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign residue = rem_ff;

endmodule

>>> rtl/gda_alu.sv
// Shared subtract and compare: takes either the year length or the days
// left in the month off the remaining count, and flags whether it fits.
module gda_alu import gda_pkg::*; (
   input  logic [MONTH_WIDTH-1:0] month,
   input  logic [DAY_WIDTH-1:0]   day,
   input  logic                   leap,
   input  logic                   use_year,
   input  logic [COUNT_WIDTH-1:0] count,
   output alu_res_type            res
);

   logic [DAY_WIDTH-1:0]      mlen;
   logic [DAY_WIDTH:0]        rest;
   logic [YEAR_LEN_WIDTH-1:0] ylen;
   logic [SUB_WIDTH-1:0]      subtrahend;
   logic [SUB_WIDTH-1:0]      full;

   // days to the first of next month, including today
   always_comb begin
      mlen = month_length(month, leap);
      rest = {1'b0, mlen} - {1'b0, day} + (DAY_WIDTH + 1)'(1);
      ylen = YEAR_DAYS + YEAR_LEN_WIDTH'(leap);
      subtrahend = use_year ? SUB_WIDTH'(ylen) : SUB_WIDTH'(rest);
      full = SUB_WIDTH'(count) - subtrahend;
      res.take = ~full[SUB_WIDTH-1];
      res.diff = full[COUNT_WIDTH-1:0];
   end

endmodule

>>> rtl/gregorian_date_advance.sv
// A load passes through the residue unit, a clamp state and the output state;
// an advance takes one month or year step per pass through S_ADV, with one
// more at a 1 January whose year does not fit; a negative goes straight to S_OUT.
// One item at a time: req_tready is high only while the sequencer is idle.
// A result waiting in the output register does not block the next transfer.
// Reset (synchronous, active high) sets the date to 1 January 1900.
module gregorian_date_advance import gda_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // day_count, load_month, load_day, load_year, zero pad
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // kind
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // cur_month, cur_day, cur_year, zero pad
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // first_of_month, ignored
   output logic [1:0]                rsp_tuser
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_CLAMP,
      S_ADV,
      S_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic [MONTH_WIDTH-1:0]   month_ff, month_in;
   logic [DAY_WIDTH-1:0]     day_ff, day_in;
   logic [YEAR_WIDTH-1:0]    year_ff, year_in;
   logic [M25_WIDTH-1:0]     m25_ff, m25_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     tried_ff, tried_in;
   logic                     ignored_ff, ignored_in;
   logic [MONTH_WIDTH-1:0]   ld_month_ff, ld_month_in;
   logic [DAY_WIDTH-1:0]     ld_day_ff, ld_day_in;
   logic [YEAR_WIDTH-1:0]    ld_year_ff, ld_year_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MONTH_WIDTH-1:0]   rsp_month_ff, rsp_month_in;
   logic [DAY_WIDTH-1:0]     rsp_day_ff, rsp_day_in;
   logic [YEAR_WIDTH-1:0]    rsp_year_ff, rsp_year_in;
   logic                     rsp_ignored_ff, rsp_ignored_in;

   logic                     req_fire;
   logic                     mod_start;
   logic                     mod_done;
   logic [M25_WIDTH-1:0]     mod_residue;
   logic                     leap_cur;
   logic                     jan1;
   logic                     use_year;
   alu_res_type              alu_res;
   logic [MONTH_WIDTH-1:0]   ld_month_sat;
   logic                     ld_leap;
   logic [DAY_WIDTH-1:0]     ld_lim;
   logic [DAY_WIDTH-1:0]     ld_day_sat;
   logic [COUNT_WIDTH-1:0]   req_count;
   logic [YEAR_WIDTH-1:0]    year_next;
   logic [M25_WIDTH-1:0]     m25_next;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_count  = req_tdata[COUNT_WIDTH-1:0];
   assign mod_start  = req_fire && (req_tuser == REQ_KIND_LOAD);

   gda_mod25 u_mod25 (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .value   (req_tdata[REQ_YEAR_LSB +: YEAR_WIDTH]),
      .done    (mod_done),
      .residue (mod_residue)
   );

   // years are stepped at 1 January while one fits, then the month step takes over
   assign leap_cur = is_leap(year_ff[3:0], m25_ff);
   assign jan1     = (month_ff == MONTH_JAN) && (day_ff == DAY_FIRST);
   assign use_year = jan1 && !tried_ff;

   gda_alu u_alu (
      .month    (month_ff),
      .day      (day_ff),
      .leap     (leap_cur),
      .use_year (use_year),
      .count    (count_ff),
      .res      (alu_res)
   );

   // next year with wrap; residue follows, and restarts at year zero
   always_comb begin
      year_next = year_ff + YEAR_WIDTH'(1);
      if (year_ff == '1) begin
         m25_next = '0;
      end else if (m25_ff == M25_WIDTH'(CENTURY_FACTOR - 1)) begin
         m25_next = '0;
      end else begin
         m25_next = m25_ff + M25_WIDTH'(1);
      end
   end

   // saturate the loaded month and day into a valid date
   always_comb begin
      if (ld_month_ff < MONTH_JAN) begin
         ld_month_sat = MONTH_JAN;
      end else if (ld_month_ff > MONTH_DEC) begin
         ld_month_sat = MONTH_DEC;
      end else begin
         ld_month_sat = ld_month_ff;
      end
      ld_leap = is_leap(ld_year_ff[3:0], mod_residue);
      ld_lim  = month_length(ld_month_sat, ld_leap);
      if (ld_day_ff < DAY_FIRST) begin
         ld_day_sat = DAY_FIRST;
      end else if (ld_day_ff > ld_lim) begin
         ld_day_sat = ld_lim;
      end else begin
         ld_day_sat = ld_day_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      month_in       = month_ff;
      day_in         = day_ff;
      year_in        = year_ff;
      m25_in         = m25_ff;
      count_in       = count_ff;
      tried_in       = tried_ff;
      ignored_in     = ignored_ff;
      ld_month_in    = ld_month_ff;
      ld_day_in      = ld_day_ff;
      ld_year_in     = ld_year_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_month_in   = rsp_month_ff;
      rsp_day_in     = rsp_day_ff;
      rsp_year_in    = rsp_year_ff;
      rsp_ignored_in = rsp_ignored_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ignored_in = 1'b0;
               tried_in   = 1'b0;
               if (req_tuser == REQ_KIND_LOAD) begin
                  ld_month_in = req_tdata[REQ_MONTH_LSB +: MONTH_WIDTH];
                  ld_day_in   = req_tdata[REQ_DAY_LSB +: DAY_WIDTH];
                  ld_year_in  = req_tdata[REQ_YEAR_LSB +: YEAR_WIDTH];
                  state_in    = S_MOD;
               end else if (req_count[COUNT_WIDTH-1]) begin
                  ignored_in = 1'b1;
                  state_in   = S_OUT;
               end else begin
                  count_in = req_count;
                  state_in = S_ADV;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            month_in = ld_month_sat;
            day_in   = ld_day_sat;
            year_in  = ld_year_ff;
            m25_in   = mod_residue;
            state_in = S_OUT;
         end
         S_ADV: begin
            if (use_year) begin
               if (alu_res.take) begin
                  count_in = alu_res.diff;
                  year_in  = year_next;
                  m25_in   = m25_next;
               end else begin
                  tried_in = 1'b1;
               end
            end else if (alu_res.take) begin
               count_in = alu_res.diff;
               tried_in = 1'b0;
               day_in   = DAY_FIRST;
               if (month_ff == MONTH_DEC) begin
                  month_in = MONTH_JAN;
                  year_in  = year_next;
                  m25_in   = m25_next;
               end else begin
                  month_in = month_ff + MONTH_WIDTH'(1);
               end
            end else begin
               // remainder is below the days left, so it fits the day field
               day_in   = day_ff + count_ff[DAY_WIDTH-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_month_in   = month_ff;
               rsp_day_in     = day_ff;
               rsp_year_in    = year_ff;
               rsp_ignored_in = ignored_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      count_ff       <= count_in;
      tried_ff       <= tried_in;
      ignored_ff     <= ignored_in;
      ld_month_ff    <= ld_month_in;
      ld_day_ff      <= ld_day_in;
      ld_year_ff     <= ld_year_in;
      rsp_month_ff   <= rsp_month_in;
      rsp_day_ff     <= rsp_day_in;
      rsp_year_ff    <= rsp_year_in;
      rsp_ignored_ff <= rsp_ignored_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         month_ff     <= MONTH_JAN;
         day_ff       <= DAY_FIRST;
         year_ff      <= RESET_YEAR;
         m25_ff       <= RESET_M25;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
         year_ff      <= year_in;
         m25_ff       <= m25_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_year_ff, rsp_day_ff, rsp_month_ff});
   assign rsp_tuser  = {rsp_ignored_ff, rsp_day_ff == DAY_FIRST};

   // stored date stays a valid calendar date between items
   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         (month_ff >= MONTH_JAN) && (month_ff <= MONTH_DEC) &&
         (day_ff >= DAY_FIRST) && (day_ff <= month_length(month_ff, leap_cur)))
      else $error("stored date out of range");

   // residue register never leaves its range
   a_m25_range: assert property (@(posedge clock) disable iff (reset)
      m25_ff < M25_WIDTH'(CENTURY_FACTOR))
      else $error("year residue out of range");

   // a year step only happens from 1 January or from a December month step
   a_year_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADV) && (year_in != year_ff) |-> jan1 ||
         ((month_ff == MONTH_DEC) && alu_res.take))
      else $error("year stepped from a mid-year date");

   // an ignored advance leaves the date untouched
   a_ignored_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && req_fire && (req_tuser == REQ_KIND_ADVANCE) &&
         req_count[COUNT_WIDTH-1] |=>
         (state_ff == S_OUT) && ignored_ff && $stable(month_ff) &&
         $stable(day_ff) && $stable(year_ff))
      else $error("ignored advance changed the date");

endmodule

>>> tb/sv/tb_gregorian_date_advance.sv
`timescale 1ns / 100ps

module tb_gregorian_date_advance;
   import gda_pkg::*;

   localparam int CLOCK_HIGH_NS = 6;
   localparam int CLOCK_LOW_NS  = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 1926;
   localparam int MAX_WAIT      = 17;
   localparam int DRAIN_CYCLES  = 150;
   localparam int CYCLE_LIMIT   = 1500000;
   localparam int MAX_REPORTS   = 10;
   // long receiver hold-off so that the block fills up and stalls its input
   localparam int HOLD_AT_RESULT = 700;
   localparam int HOLD_CYCLES    = 600;

   // one result, unpacked from rsp_tdata and rsp_tuser
   typedef struct packed {
      logic [MONTH_WIDTH-1:0] month;
      logic [DAY_WIDTH-1:0]   day;
      logic [YEAR_WIDTH-1:0]  year;
      logic                   first_of_month;
      logic                   ignored;
   } date_rsp_type;

   typedef struct packed {
      logic                   kind;
      logic [COUNT_WIDTH-1:0] day_count;
      logic [MONTH_WIDTH-1:0] month;
      logic [DAY_WIDTH-1:0]   day;
      logic [YEAR_WIDTH-1:0]  year;
      logic                   typed;
      date_rsp_type           want;
   } directed_row_type;

   localparam date_rsp_type NO_WANT = '0;

   localparam int NUM_DIRECTED = 24;
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // zero count straight after reset
      '{REQ_KIND_ADVANCE, 16'd0,     4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd1,  5'd1,  14'd1900,  1'b1, 1'b0}},
      // negative counts are dropped
      '{REQ_KIND_ADVANCE, 16'hFFFF,  4'd15, 5'd31, 14'h3FFF,  1'b1,
        '{4'd1,  5'd1,  14'd1900,  1'b1, 1'b1}},
      '{REQ_KIND_ADVANCE, 16'h8000,  4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd1,  5'd1,  14'd1900,  1'b1, 1'b1}},
      // month and day saturate on load
      '{REQ_KIND_LOAD,    16'hFFFF,  4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd1,  5'd1,  14'd0,     1'b1, 1'b0}},
      '{REQ_KIND_LOAD,    16'd0,     4'd15, 5'd31, 14'd16383, 1'b1,
        '{4'd12, 5'd31, 14'd16383, 1'b0, 1'b0}},
      // year wraps to zero, and year zero is a leap year
      '{REQ_KIND_ADVANCE, 16'd1,     4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd1,  5'd1,  14'd0,     1'b1, 1'b0}},
      '{REQ_KIND_ADVANCE, 16'd366,   4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd1,  5'd1,  14'd1,     1'b1, 1'b0}},
      // February length in century and leap years, then a short month and its end
      '{REQ_KIND_LOAD,    16'd0,     4'd2,  5'd31, 14'd1900,  1'b1,
        '{4'd2,  5'd28, 14'd1900,  1'b0, 1'b0}},
      '{REQ_KIND_LOAD,    16'd0,     4'd2,  5'd31, 14'd2000,  1'b1,
        '{4'd2,  5'd29, 14'd2000,  1'b0, 1'b0}},
      '{REQ_KIND_LOAD,    16'd0,     4'd2,  5'd30, 14'd2004,  1'b1,
        '{4'd2,  5'd29, 14'd2004,  1'b0, 1'b0}},
      '{REQ_KIND_LOAD,    16'd0,     4'd4,  5'd31, 14'd2021,  1'b1,
        '{4'd4,  5'd30, 14'd2021,  1'b0, 1'b0}},
      '{REQ_KIND_ADVANCE, 16'd1,     4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd5,  5'd1,  14'd2021,  1'b1, 1'b0}},
      '{REQ_KIND_ADVANCE, 16'd0,     4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd5,  5'd1,  14'd2021,  1'b1, 1'b0}},
      // whole-year step from 1 January, then further century and year-end cases
      '{REQ_KIND_LOAD,    16'd0,     4'd1,  5'd1,  14'd2023,  1'b1,
        '{4'd1,  5'd1,  14'd2023,  1'b1, 1'b0}},
      '{REQ_KIND_ADVANCE, 16'd365,   4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd1,  5'd1,  14'd2024,  1'b1, 1'b0}},
      '{REQ_KIND_ADVANCE, 16'h7FFF,  4'd0,  5'd0,  14'd0,     1'b0, NO_WANT},
      '{REQ_KIND_LOAD,    16'd0,     4'd2,  5'd28, 14'd2100,  1'b1,
        '{4'd2,  5'd28, 14'd2100,  1'b0, 1'b0}},
      '{REQ_KIND_ADVANCE, 16'd1,     4'd0,  5'd0,  14'd0,     1'b1,
        '{4'd3,  5'd1,  14'd2100,  1'b1, 1'b0}},
      '{REQ_KIND_LOAD,    16'd0,     4'd12, 5'd31, 14'd2399,  1'b1,
        '{4'd12, 5'd31, 14'd2399,  1'b0, 1'b0}},
      '{REQ_KIND_ADVANCE, 16'd60,    4'd0,  5'd0,  14'd0,     1'b0, NO_WANT},
      '{REQ_KIND_LOAD,    16'd0,     4'd7,  5'd15, 14'd16383, 1'b0, NO_WANT},
      '{REQ_KIND_ADVANCE, 16'h7FFF,  4'd0,  5'd0,  14'd0,     1'b0, NO_WANT},
      '{REQ_KIND_ADVANCE, 16'h5555,  4'd10, 5'd10, 14'h1555,  1'b0, NO_WANT},
      '{REQ_KIND_LOAD,    16'hAAAA,  4'd9,  5'd17, 14'h2AAA,  1'b0, NO_WANT}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // day_count, load_month, load_day, load_year, zero pad
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   // kind
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // cur_month, cur_day, cur_year, zero pad
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   // first_of_month, ignored
   logic [1:0]                rsp_tuser;

   // calendar date held by the predictor
   logic [MONTH_WIDTH-1:0] cal_month = MONTH_JAN;
   logic [DAY_WIDTH-1:0]   cal_day   = DAY_FIRST;
   logic [YEAR_WIDTH-1:0]  cal_year  = RESET_YEAR;

   date_rsp_type pending_dates [$];
   int        error_count    = 0;
   int        mismatch_count = 0;
   int        dates_returned = 0;
   int        cycle_count    = 0;
   logic      stim_done      = 1'b0;
   logic      send_quiet     = 1'b0;

   gregorian_date_advance u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always begin
      #CLOCK_LOW_NS clock = 1'b1;
      #CLOCK_HIGH_NS clock = 1'b0;
   end

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_dates.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic int unsigned year_days(input logic [YEAR_WIDTH-1:0] y);
      int unsigned v;
      v = y;
      if ((v % 400 == 0) || ((v % 4 == 0) && (v % 100 != 0))) begin
         return 366;
      end
      return 365;
   endfunction

   function automatic int unsigned days_in_month(input logic [MONTH_WIDTH-1:0] m,
                                                 input logic [YEAR_WIDTH-1:0] y);
      if (m == MONTH_FEB) begin
         return year_days(y) - 337;
      end else if ((m == MONTH_APR) || (m == MONTH_JUN) ||
                   (m == MONTH_SEP) || (m == MONTH_NOV)) begin
         return 30;
      end
      return 31;
   endfunction

   // applies one transfer to the held date and returns the date it yields
   function automatic date_rsp_type next_date(input logic                   kind,
                                              input logic [COUNT_WIDTH-1:0] count,
                                              input logic [MONTH_WIDTH-1:0] load_month,
                                              input logic [DAY_WIDTH-1:0]   load_day,
                                              input logic [YEAR_WIDTH-1:0]  load_year);
      int unsigned  m;
      int unsigned  d;
      int unsigned  lim;
      int unsigned  n;
      int unsigned  rest;
      date_rsp_type r;
      r = '0;
      if (kind == REQ_KIND_LOAD) begin
         m = load_month;
         d = load_day;
         if (m < MONTH_JAN) m = MONTH_JAN;
         if (m > MONTH_DEC) m = MONTH_DEC;
         lim = days_in_month(MONTH_WIDTH'(m), load_year);
         if (d < DAY_FIRST) d = DAY_FIRST;
         if (d > lim) d = lim;
         cal_month = MONTH_WIDTH'(m);
         cal_day   = DAY_WIDTH'(d);
         cal_year  = load_year;
      end else if (count[COUNT_WIDTH-1]) begin
         r.ignored = 1'b1;
      end else begin
         n = count;
         rest = days_in_month(cal_month, cal_year) - cal_day + 1;
         while (n >= rest) begin
            if ((cal_month == MONTH_JAN) && (cal_day == DAY_FIRST) &&
                (n >= year_days(cal_year))) begin
               n = n - year_days(cal_year);
               cal_year = cal_year + 1'b1;
            end else begin
               n = n - rest;
               cal_day = DAY_FIRST;
               if (cal_month == MONTH_DEC) begin
                  cal_month = MONTH_JAN;
                  cal_year  = cal_year + 1'b1;
               end else begin
                  cal_month = cal_month + 1'b1;
               end
            end
            rest = days_in_month(cal_month, cal_year) - cal_day + 1;
         end
         cal_day = cal_day + DAY_WIDTH'(n);
      end
      r.month          = cal_month;
      r.day            = cal_day;
      r.year           = cal_year;
      r.first_of_month = (cal_day == DAY_FIRST);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: called at a falling edge, returns at the falling edge after
   // the transfer
   // ---------------------------------------------------------------------

   task automatic send_item(input logic                   kind,
                            input logic [COUNT_WIDTH-1:0] count,
                            input logic [MONTH_WIDTH-1:0] month,
                            input logic [DAY_WIDTH-1:0]   day,
                            input logic [YEAR_WIDTH-1:0]  year,
                            input logic                   typed,
                            input date_rsp_type           want);
      int unsigned  gap;
      date_rsp_type predicted;
      gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= REQ_DATA_WIDTH'({year, day, month, count});
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = next_date(kind, count, month, day, year);
      pending_dates.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // random transfer: mostly advances of every size, loads partly aimed at the
   // awkward corners of the calendar
   task automatic send_random;
      logic                   kind;
      logic [COUNT_WIDTH-1:0] count;
      logic [MONTH_WIDTH-1:0] month;
      logic [DAY_WIDTH-1:0]   day;
      logic [YEAR_WIDTH-1:0]  year;
      int unsigned            pick;
      count = COUNT_WIDTH'($urandom_range(0, 16'hFFFF));
      month = MONTH_WIDTH'($urandom_range(0, 15));
      day   = DAY_WIDTH'($urandom_range(0, 31));
      year  = YEAR_WIDTH'($urandom_range(0, 16383));
      if ($urandom_range(0, 99) < 20) begin
         kind = REQ_KIND_LOAD;
         if ($urandom_range(0, 9) != 0) month = MONTH_WIDTH'($urandom_range(1, 12));
         pick = $urandom_range(0, 9);
         case (pick)
            0: year = YEAR_WIDTH'($urandom_range(16380, 16383));
            1: year = YEAR_WIDTH'(100 * $urandom_range(15, 25));
            2: year = YEAR_WIDTH'(4 * $urandom_range(0, 4095));
            default: ;
         endcase
      end else begin
         kind = REQ_KIND_ADVANCE;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            count[COUNT_WIDTH-1] = 1'b1;
         end else if (pick < 15) begin
            count = '0;
         end else if (pick < 50) begin
            count = COUNT_WIDTH'($urandom_range(1, 40));
         end else if (pick < 75) begin
            count = COUNT_WIDTH'($urandom_range(0, 400));
         end else if (pick < 90) begin
            count = COUNT_WIDTH'($urandom_range(0, 3000));
         end else begin
            count = COUNT_WIDTH'($urandom_range(0, 32767));
         end
      end
      send_item(kind, count, month, day, year, 1'b0, NO_WANT);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         send_item(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].day_count,
                   DIRECTED_ROWS[i].month, DIRECTED_ROWS[i].day,
                   DIRECTED_ROWS[i].year, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);
      end

      // random part, with a back-to-back stretch every fourth block
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_quiet = ((i / 150) % 4 == 3);
         send_random();
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;

      // drain, then allow for any stray transfer
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      error_count = error_count + pending_dates.size();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver and result check
   // ---------------------------------------------------------------------

   task automatic check_date(input date_rsp_type got);
      date_rsp_type want;
      if (pending_dates.size() == 0) begin
         error_count = error_count + 1;
         if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: result with nothing expected: %p", $time, got);
         end
         mismatch_count = mismatch_count + 1;
      end else begin
         want = pending_dates.pop_front();
         if ((got.month !== want.month) || (got.day !== want.day) ||
             (got.year !== want.year) ||
             (got.first_of_month !== want.first_of_month) ||
             (got.ignored !== want.ignored)) begin
            error_count = error_count + 1;
            if (mismatch_count < MAX_REPORTS) begin
               $display("%0t: result %0d mismatch: expected %p, got %p",
                        $time, dates_returned, want, got);
            end
            mismatch_count = mismatch_count + 1;
         end
      end
   endtask

   initial begin
      int unsigned  stall;
      logic         rsp_quiet;
      date_rsp_type got;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_quiet = ((dates_returned / 130) % 5 == 2);
         if (dates_returned == HOLD_AT_RESULT) begin
            stall = HOLD_CYCLES;
         end else if (rsp_quiet || (stim_done && pending_dates.size() == 0)) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_WAIT);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.month          = rsp_tdata[MONTH_WIDTH-1:0];
         got.day            = rsp_tdata[MONTH_WIDTH +: DAY_WIDTH];
         got.year           = rsp_tdata[MONTH_WIDTH + DAY_WIDTH +: YEAR_WIDTH];
         got.first_of_month = rsp_tuser[0];
         got.ignored        = rsp_tuser[1];
         check_date(got);
         dates_returned = dates_returned + 1;
         @(negedge clock);
      end
   end

endmodule
